@@ src/source_token_lexer_assert.svh @@
// ----------------------------------------------------------------------------
// source_token_lexer_assert.svh
// Assertion macros used by the top-level lexer module.
// ----------------------------------------------------------------------------
`ifndef SOURCE_TOKEN_LEXER_ASSERT_SVH
`define SOURCE_TOKEN_LEXER_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define STL_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define STL_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ src/stl_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stl_pkg
// Types, codes and keyword tables for the source token lexer.
// ----------------------------------------------------------------------------
package stl_pkg;

    localparam int NUM_KW  = 11;
    localparam int NUM_OPS = 6;

    localparam logic [4:0] KIND_LEXEME  = 5'd0;
    localparam logic [4:0] KIND_IDENT   = 5'd1;
    localparam logic [4:0] KIND_INT     = 5'd2;
    localparam logic [4:0] KIND_DOUBLE  = 5'd3;
    localparam logic [4:0] KIND_EOF     = 5'd4;
    localparam logic [4:0] KIND_OP_BASE = 5'd14;
    localparam logic [4:0] KIND_SINGLE  = 5'd20;

    localparam logic [2:0] OP_EQ    = 3'd0;
    localparam logic [2:0] OP_NOT   = 3'd1;
    localparam logic [2:0] OP_GT    = 3'd2;
    localparam logic [2:0] OP_LT    = 3'd3;
    localparam logic [2:0] OP_PLUS  = 3'd4;
    localparam logic [2:0] OP_MINUS = 3'd5;

    localparam logic [7:0] CHAR_SLASH = 8'h2F;

    localparam logic [NUM_KW-1:0] ALL_KW = '1;

    // keyword text, right aligned: first character is the most significant byte
    localparam logic [55:0] KW_WORD [NUM_KW] = '{
        56'("int"), 56'("double"), 56'("byte"), 56'("bool"), 56'("true"),
        56'("false"), 56'("if"), 56'("else"), 56'("while"), 56'("char"),
        56'("int8")
    };
    localparam logic [2:0] KW_LEN [NUM_KW] = '{
        3'd3, 3'd6, 3'd4, 3'd4, 3'd4, 3'd5, 3'd2, 3'd4, 3'd5, 3'd4, 3'd4
    };
    localparam logic [4:0] KW_KIND [NUM_KW] = '{
        5'd5, 5'd6, 5'd7, 5'd8, 5'd9, 5'd10, 5'd11, 5'd12, 5'd13, 5'd7, 5'd7
    };

    typedef enum logic [3:0] {
        MODE_BETWEEN,
        MODE_IDENT,
        MODE_INT,
        MODE_DBL,
        MODE_OP,
        MODE_SLASH,
        MODE_LINE,
        MODE_BLOCK,
        MODE_BSTAR
    } lex_mode_t;

    typedef enum logic [3:0] {
        CLS_NUL,
        CLS_SPACE,
        CLS_NEWLINE,
        CLS_ALPHA,
        CLS_DIGIT,
        CLS_UNDER,
        CLS_DOT,
        CLS_SLASH,
        CLS_STAR,
        CLS_OP,
        CLS_OTHER
    } char_cls_t;

    typedef struct packed {
        logic [7:0] src_byte;
        char_cls_t  cls;
        logic [2:0] op_idx;
    } item_t;

    typedef struct packed {
        logic empty;
        logic full;
    } q_stat_t;

    typedef struct packed {
        logic [4:0] kind;
        logic [7:0] value;
    } res_t;

    function automatic logic [7:0] op_char(input logic [2:0] idx);
        logic [7:0] c;
        unique case (idx)
            OP_EQ:    c = 8'h3D;
            OP_NOT:   c = 8'h21;
            OP_GT:    c = 8'h3E;
            OP_LT:    c = 8'h3C;
            OP_PLUS:  c = 8'h2B;
            OP_MINUS: c = 8'h2D;
            default:  c = 8'h00;
        endcase
        return c;
    endfunction

    // drop every candidate that has no character at pos or whose character there differs from b
    function automatic logic [NUM_KW-1:0] kw_step(input logic [NUM_KW-1:0] cand,
                                                 input logic [2:0] pos,
                                                 input logic [7:0] b);
        logic [NUM_KW-1:0] res;
        logic [2:0]        sh;
        logic [7:0]        c;
        res = cand;
        for (int i = 0; i < NUM_KW; i++)
        begin
            sh = KW_LEN[i] - 3'd1 - pos;
            c  = KW_WORD[i][{sh, 3'b000} +: 8];
            if (pos >= KW_LEN[i] || c != b)
            begin
                res[i] = 1'b0;
            end
        end
        return res;
    endfunction

    function automatic logic [4:0] ident_kind(input logic [NUM_KW-1:0] cand,
                                              input logic [2:0] pos);
        logic [4:0] k;
        k = KIND_IDENT;
        // lowest-numbered matching keyword wins
        for (int i = NUM_KW - 1; i >= 0; i--)
        begin
            if (cand[i] && KW_LEN[i] == pos)
            begin
                k = KW_KIND[i];
            end
        end
        return k;
    endfunction

endpackage

@@ src/stl_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stl_front
// Accepts source bytes and tags each with its character class.
// ----------------------------------------------------------------------------
module stl_front
    import stl_pkg::*;
(
    input  logic       src_valid,
    output logic       src_stall,
    input  logic [7:0] src_byte,
    input  q_stat_t    q_stat,
    output logic       push,
    output item_t      push_item
);

    char_cls_t  cls;
    logic [2:0] op_idx;

    always_comb
    begin
        op_idx = OP_EQ;
        priority if (src_byte == 8'h00)
            cls = CLS_NUL;
        else if (src_byte == 8'h20 || src_byte == 8'h09)
            cls = CLS_SPACE;
        else if (src_byte == 8'h0A || src_byte == 8'h0D)
            cls = CLS_NEWLINE;
        else if ((src_byte >= 8'h61 && src_byte <= 8'h7A) ||
                 (src_byte >= 8'h41 && src_byte <= 8'h5A))
            cls = CLS_ALPHA;
        else if (src_byte >= 8'h30 && src_byte <= 8'h39)
            cls = CLS_DIGIT;
        else if (src_byte == 8'h5F)
            cls = CLS_UNDER;
        else if (src_byte == 8'h2E)
            cls = CLS_DOT;
        else if (src_byte == CHAR_SLASH)
            cls = CLS_SLASH;
        else if (src_byte == 8'h2A)
            cls = CLS_STAR;
        else if (src_byte == op_char(OP_EQ))
            cls = CLS_OP;
        else if (src_byte == op_char(OP_NOT))
        begin
            cls    = CLS_OP;
            op_idx = OP_NOT;
        end
        else if (src_byte == op_char(OP_GT))
        begin
            cls    = CLS_OP;
            op_idx = OP_GT;
        end
        else if (src_byte == op_char(OP_LT))
        begin
            cls    = CLS_OP;
            op_idx = OP_LT;
        end
        else if (src_byte == op_char(OP_PLUS))
        begin
            cls    = CLS_OP;
            op_idx = OP_PLUS;
        end
        else if (src_byte == op_char(OP_MINUS))
        begin
            cls    = CLS_OP;
            op_idx = OP_MINUS;
        end
        else
            cls = CLS_OTHER;
    end

    assign src_stall          = q_stat.full;
    assign push               = src_valid && !q_stat.full;
    assign push_item.src_byte = src_byte;
    assign push_item.cls      = cls;
    assign push_item.op_idx   = op_idx;

endmodule

@@ src/stl_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stl_queue
// Small register queue of classified items between front and back.
// ----------------------------------------------------------------------------
module stl_queue
    import stl_pkg::*;
#(
    parameter int DEPTH = 4
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  item_t   push_item,
    input  logic    pop,
    output item_t   head_item,
    output q_stat_t q_stat
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    item_t             entry_reg [DEPTH];
    logic [PTR_W-1:0]  head_reg, head_next;
    logic [PTR_W-1:0]  tail_reg, tail_next;
    logic [CNT_W-1:0]  count_reg, count_next;

    always_comb
    begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        if (push)
        begin
            tail_next = (tail_reg == LAST_PTR) ? '0 : tail_reg + 1'b1;
        end
        if (pop)
        begin
            head_next = (head_reg == LAST_PTR) ? '0 : head_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[tail_reg] <= push_item;
        end
    end

    assign head_item    = entry_reg[head_reg];
    assign q_stat.empty = (count_reg == '0);
    assign q_stat.full  = (count_reg == FULL_CNT);

endmodule

@@ src/stl_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stl_back
// Lexer state machine: turns classified items into tokens, one result a cycle unless stalled.
// ----------------------------------------------------------------------------
module stl_back
    import stl_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  item_t      head_item,
    input  q_stat_t    q_stat,
    output logic       pop,
    output logic       tok_valid,
    input  logic       tok_stall,
    output logic [4:0] kind,
    output logic [7:0] char_value,
    output logic       last
);

    lex_mode_t         mode_reg, mode_next;
    logic [2:0]        pend_reg, pend_next;
    logic [NUM_KW-1:0] cand_reg, cand_next;
    logic [2:0]        wpos_reg, wpos_next;
    logic              sub_reg, sub_next;
    logic              tok_valid_reg, tok_valid_next;
    logic [4:0]        kind_reg;
    logic [7:0]        value_reg;
    logic              last_reg;

    // results of the head item against the current state
    res_t       r0, r1;
    logic [1:0] n_res;
    logic       have_head, can_load, load;
    res_t       load_res;
    logic       load_last;

    // start of a new token
    lex_mode_t         st_mode;
    logic [2:0]        st_pend;
    logic [NUM_KW-1:0] st_cand;
    logic [2:0]        st_wpos;
    logic              st_emit;
    res_t              st_res;

    logic       pre_emit, do_start;
    res_t       pre_res;
    logic [7:0] b;
    char_cls_t  cls;
    logic       word_char, op_match;

    assign b   = head_item.src_byte;
    assign cls = head_item.cls;

    always_comb
    begin
        st_mode = MODE_BETWEEN;
        st_pend = pend_reg;
        st_cand = cand_reg;
        st_wpos = wpos_reg;
        st_emit = 1'b0;
        st_res  = '0;
        unique case (cls)
            CLS_NUL:
            begin
                st_emit     = 1'b1;
                st_res.kind = KIND_EOF;
            end
            CLS_SPACE, CLS_NEWLINE:
            begin
            end
            CLS_ALPHA:
            begin
                st_mode = MODE_IDENT;
                st_cand = kw_step(ALL_KW, 3'd0, b);
                st_wpos = 3'd1;
                st_emit = 1'b1;
                st_res  = '{kind: KIND_LEXEME, value: b};
            end
            CLS_DIGIT:
            begin
                st_mode = MODE_INT;
                st_emit = 1'b1;
                st_res  = '{kind: KIND_LEXEME, value: b};
            end
            CLS_SLASH:
                st_mode = MODE_SLASH;
            CLS_OP:
            begin
                st_mode = MODE_OP;
                st_pend = head_item.op_idx;
            end
            default:
            begin
                st_emit = 1'b1;
                st_res  = '{kind: KIND_SINGLE, value: b};
            end
        endcase
    end

    assign word_char = (cls == CLS_ALPHA) || (cls == CLS_DIGIT) || (cls == CLS_UNDER);
    assign op_match  = (cls == CLS_OP) && (pend_reg < 3'(NUM_OPS)) &&
                       ((pend_reg < OP_PLUS) ? (head_item.op_idx == OP_EQ)
                                             : (head_item.op_idx == pend_reg));

    always_comb
    begin
        mode_next = mode_reg;
        pend_next = pend_reg;
        cand_next = cand_reg;
        wpos_next = wpos_reg;
        pre_emit  = 1'b0;
        pre_res   = '0;
        do_start  = 1'b0;
        unique case (mode_reg)
            MODE_IDENT:
            begin
                if (word_char)
                begin
                    cand_next = kw_step(cand_reg, wpos_reg, b);
                    wpos_next = (wpos_reg == 3'd7) ? 3'd7 : wpos_reg + 3'd1;
                    pre_emit  = 1'b1;
                    pre_res   = '{kind: KIND_LEXEME, value: b};
                end
                else
                begin
                    pre_emit     = 1'b1;
                    pre_res.kind = ident_kind(cand_reg, wpos_reg);
                    do_start     = 1'b1;
                end
            end
            MODE_INT, MODE_DBL:
            begin
                if (cls == CLS_DIGIT || cls == CLS_DOT)
                begin
                    if (cls == CLS_DOT)
                    begin
                        mode_next = MODE_DBL;
                    end
                    pre_emit = 1'b1;
                    pre_res  = '{kind: KIND_LEXEME, value: b};
                end
                else
                begin
                    pre_emit     = 1'b1;
                    pre_res.kind = (mode_reg == MODE_DBL) ? KIND_DOUBLE : KIND_INT;
                    do_start     = 1'b1;
                end
            end
            MODE_OP:
            begin
                pre_emit = 1'b1;
                if (op_match)
                begin
                    pre_res.kind = KIND_OP_BASE + {2'b00, pend_reg};
                    mode_next    = MODE_BETWEEN;
                end
                else
                begin
                    pre_res  = '{kind: KIND_SINGLE, value: op_char(pend_reg)};
                    do_start = 1'b1;
                end
            end
            MODE_SLASH:
            begin
                priority if (cls == CLS_SLASH)
                    mode_next = MODE_LINE;
                else if (cls == CLS_STAR)
                    mode_next = MODE_BLOCK;
                else
                begin
                    pre_emit = 1'b1;
                    pre_res  = '{kind: KIND_SINGLE, value: CHAR_SLASH};
                    do_start = 1'b1;
                end
            end
            MODE_LINE:
            begin
                if (cls == CLS_NUL)
                begin
                    pre_emit     = 1'b1;
                    pre_res.kind = KIND_EOF;
                    mode_next    = MODE_BETWEEN;
                end
                else if (cls == CLS_NEWLINE)
                begin
                    mode_next = MODE_BETWEEN;
                end
            end
            MODE_BLOCK:
            begin
                if (cls == CLS_NUL)
                begin
                    pre_emit     = 1'b1;
                    pre_res.kind = KIND_EOF;
                    mode_next    = MODE_BETWEEN;
                end
                else if (cls == CLS_STAR)
                begin
                    mode_next = MODE_BSTAR;
                end
            end
            MODE_BSTAR:
            begin
                priority if (cls == CLS_NUL)
                begin
                    pre_emit     = 1'b1;
                    pre_res.kind = KIND_EOF;
                    mode_next    = MODE_BETWEEN;
                end
                else if (cls == CLS_SLASH)
                    mode_next = MODE_BETWEEN;
                else if (cls != CLS_STAR)
                    mode_next = MODE_BLOCK;
            end
            default:
                do_start = 1'b1;
        endcase

        if (do_start)
        begin
            mode_next = st_mode;
            pend_next = st_pend;
            cand_next = st_cand;
            wpos_next = st_wpos;
        end

        r0    = '0;
        r1    = '0;
        n_res = 2'd0;
        if (pre_emit)
        begin
            r0    = pre_res;
            n_res = 2'd1;
        end
        if (do_start && st_emit)
        begin
            if (pre_emit)
            begin
                r1    = st_res;
                n_res = 2'd2;
            end
            else
            begin
                r0    = st_res;
                n_res = 2'd1;
            end
        end
    end

    // Sequencer: an item leaves the queue once its last result, if it has any, is loaded.
    assign have_head = !q_stat.empty;
    assign can_load  = !tok_valid_reg || !tok_stall;
    assign pop  = have_head &&
                  ((n_res == 2'd0) || (can_load && ((n_res == 2'd1) || sub_reg)));
    assign load = have_head && can_load && (n_res != 2'd0);

    always_comb
    begin
        load_res  = sub_reg ? r1 : r0;
        load_last = 1'b1;
        if (n_res == 2'd2 && !sub_reg)
        begin
            load_last = 1'b0;
        end

        sub_next = sub_reg;
        if (load && n_res == 2'd2 && !sub_reg)
            sub_next = 1'b1;
        else if (pop)
            sub_next = 1'b0;

        if (load)
            tok_valid_next = 1'b1;
        else if (can_load)
            tok_valid_next = 1'b0;
        else
            tok_valid_next = tok_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= MODE_BETWEEN;
            cand_reg      <= ALL_KW;
            wpos_reg      <= 3'd0;
            sub_reg       <= 1'b0;
            tok_valid_reg <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                mode_reg <= mode_next;
                cand_reg <= cand_next;
                wpos_reg <= wpos_next;
            end
            sub_reg       <= sub_next;
            tok_valid_reg <= tok_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            pend_reg <= pend_next;
        end
        if (load)
        begin
            kind_reg  <= load_res.kind;
            value_reg <= load_res.value;
            last_reg  <= load_last;
        end
    end

    assign tok_valid  = tok_valid_reg;
    assign kind       = kind_reg;
    assign char_value = value_reg;
    assign last       = last_reg;

endmodule

@@ src/source_token_lexer.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// source_token_lexer
// Streaming tokenizer for a small C-like language, one source byte per item.
// ----------------------------------------------------------------------------
//  channel  handshake            payload
//  src      src_valid/src_stall  src_byte[7:0]
//  tok      tok_valid/tok_stall  kind[4:0], char_value[7:0], last
//
// A byte is taken every cycle while the queue has room; a byte that yields
// two results holds the lexer state machine until both are loaded into the output
// register; bytes that yield none pass at one per cycle, bytes that yield one likewise unless tok_stall holds.
// An accepted byte is written into the queue; its first result is then registered at the output.
// Reset returns the lexer to between tokens with an empty queue.
// tok_stall holds the output register; the queue absorbs QUEUE_DEPTH bytes.
// ----------------------------------------------------------------------------
module source_token_lexer
    import stl_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       src_valid,
    output logic       src_stall,
    input  logic [7:0] src_byte,
    output logic       tok_valid,
    input  logic       tok_stall,
    output logic [4:0] kind,
    output logic [7:0] char_value,
    output logic       last
);

`include "source_token_lexer_assert.svh"

    q_stat_t q_stat;
    logic    push, pop;
    item_t   push_item, head_item;

    stl_front u_front (
        .src_valid (src_valid),
        .src_stall (src_stall),
        .src_byte  (src_byte),
        .q_stat    (q_stat),
        .push      (push),
        .push_item (push_item)
    );

    stl_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .head_item (head_item),
        .q_stat    (q_stat)
    );

    stl_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_item  (head_item),
        .q_stat     (q_stat),
        .pop        (pop),
        .tok_valid  (tok_valid),
        .tok_stall  (tok_stall),
        .kind       (kind),
        .char_value (char_value),
        .last       (last)
    );

    `STL_ASSERT_NOW(a_pop_nonempty, pop, !q_stat.empty, "pop from empty queue")
    `STL_ASSERT_NEXT(a_second_follows, tok_valid && !last, tok_valid, "second result missing")
    `STL_ASSERT_NOW(a_eof_final, tok_valid && kind == KIND_EOF, last && char_value == 8'h00, "eof not final")

endmodule
